// File: design/swf_pkg.sv
// swf_pkg: shared sizes, types and the dominance test for the skyline window filter
// used by swf_cell and skyline_window_filter_core; no dependencies
package swf_pkg;

	localparam int WINDOW_DEPTH   = 64;
	localparam int MAX_DIMS       = 4;
	localparam int COORD_BITS     = 16;
	localparam int FIELD_BITS     = 16;
	localparam int ID_BITS        = 16;
	localparam int DIMS_BITS      = 3;
	localparam int COUNT_OUT_BITS = 7;
	localparam int CNT_BITS       = $clog2(WINDOW_DEPTH + 1);

	typedef logic [COORD_BITS-1:0]     coord_t;
	typedef coord_t [MAX_DIMS-1:0]     point_t;
	typedef logic [MAX_DIMS-1:0]       dim_mask_t;
	typedef logic [CNT_BITS-1:0]       count_t;
	typedef logic [DIMS_BITS-1:0]      dims_t;

	// one request on its way down the chain of cells
	typedef struct packed {
		logic               valid;
		point_t             coords;
		logic [ID_BITS-1:0] id;
		logic               last;
		logic               dominated;
		logic               kept;
		count_t             count;
	} probe_t;

	// w dominates p: no greater in every used coordinate, smaller in at least one
	function automatic logic dominates(point_t w, point_t p, dim_mask_t m);
		logic no_greater;
		logic smaller;
		no_greater = 1'b1;
		smaller    = 1'b0;
		for (int k = 0; k < MAX_DIMS; k++) begin
			if (m[k]) begin
				if (w[k] > p[k]) no_greater = 1'b0;
				if (w[k] < p[k]) smaller = 1'b1;
			end
		end
		return no_greater && smaller;
	endfunction

endpackage

// File: design/swf_cell.sv
// swf_cell: one window slot of the skyline filter, compares the passing request
// with its stored point and hands the request to the next cell; uses swf_pkg
module swf_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  swf_pkg::dim_mask_t dim_mask,
	input  swf_pkg::probe_t    probe_in,
	output swf_pkg::probe_t    probe_out
);
	import swf_pkg::*;

	logic   valid_q;
	point_t entry_q;
	probe_t probe_q;
	probe_t probe_nxt;
	logic   hit;
	logic   take;

	always_comb begin
		hit  = valid_q && dominates(entry_q, probe_in.coords, dim_mask);
		// first empty slot captures a point that no earlier slot dominated
		take = probe_in.valid && !valid_q && !probe_in.dominated && !probe_in.kept;
		probe_nxt = probe_in;
		if (hit) probe_nxt.dominated = 1'b1;
		if (take) probe_nxt.kept = 1'b1;
		if (valid_q || take) probe_nxt.count = probe_in.count + count_t'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			probe_q <= '0;
		end else if (advance) begin
			probe_q <= probe_nxt;
			// the last point of a set empties each slot as it passes
			if (probe_in.valid && probe_in.last) valid_q <= 1'b0;
			else if (take) valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && take) entry_q <= probe_in.coords;
	end

	assign probe_out = probe_q;

endmodule

// File: design/skyline_window_filter_core.sv
// skyline_window_filter_core: top level of the sort-filter skyline window
// depends on swf_pkg and a chain of swf_cell slots
//
//  channel   handshake            payload
//  in        in_valid / in_stall  coord_a..coord_d, point_id, last_point
//  out       out_valid/ out_stall result_id, on_skyline, window_overflow,
//                                 skyline_count, set_done
//  cfg       cfg_valid/ cfg_ready cfg_data (dims_in_use)
//
// one point per cycle while the output does not stall; the edge that accepts a request
// loads it into the first cell, it then moves down the chain of WINDOW_DEPTH cells
// and the last cell hands over to the output register
// a stalled output freezes the whole chain, and in_stall follows it
// reset empties every slot and sets dims_in_use to 4; no clearing pass is needed
module skyline_window_filter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [swf_pkg::DIMS_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [swf_pkg::FIELD_BITS-1:0]    coord_a,
	input  logic [swf_pkg::FIELD_BITS-1:0]    coord_b,
	input  logic [swf_pkg::FIELD_BITS-1:0]    coord_c,
	input  logic [swf_pkg::FIELD_BITS-1:0]    coord_d,
	input  logic [swf_pkg::ID_BITS-1:0]       point_id,
	input  logic                              last_point,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [swf_pkg::ID_BITS-1:0]       result_id,
	output logic                              on_skyline,
	output logic                              window_overflow,
	output logic [swf_pkg::COUNT_OUT_BITS-1:0] skyline_count,
	output logic                              set_done
);
	import swf_pkg::*;

	dims_t     dims_q;
	dims_t     dims_eff;
	dim_mask_t dim_mask;
	logic      advance;
	probe_t    link [WINDOW_DEPTH+1];
	probe_t    tail;
	logic [FIELD_BITS-1:0] raw_coord [4];

	logic                      out_valid_q;
	logic [ID_BITS-1:0]        result_id_q;
	logic                      on_skyline_q;
	logic                      window_overflow_q;
	logic [COUNT_OUT_BITS-1:0] skyline_count_q;
	logic                      set_done_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= DIMS_BITS'(4);
		end else if (cfg_valid && cfg_ready) begin
			dims_q <= cfg_data;
		end
	end

	// zero reads as one dimension, anything above MAX_DIMS saturates
	always_comb begin
		dims_eff = dims_q;
		if (dims_q == '0) dims_eff = DIMS_BITS'(1);
		else if (dims_q > DIMS_BITS'(MAX_DIMS)) dims_eff = DIMS_BITS'(MAX_DIMS);
		for (int k = 0; k < MAX_DIMS; k++) begin
			dim_mask[k] = DIMS_BITS'(k) < dims_eff;
		end
	end

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = !advance;

	assign raw_coord[0] = coord_a;
	assign raw_coord[1] = coord_b;
	assign raw_coord[2] = coord_c;
	assign raw_coord[3] = coord_d;

	always_comb begin
		link[0]           = '0;
		link[0].valid     = in_valid;
		link[0].id        = point_id;
		link[0].last      = last_point;
		for (int k = 0; k < MAX_DIMS; k++) begin
			link[0].coords[k] = raw_coord[k][COORD_BITS-1:0];
		end
	end

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		swf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.dim_mask  (dim_mask),
			.probe_in  (link[i]),
			.probe_out (link[i+1])
		);
	end

	assign tail = link[WINDOW_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_id_q       <= tail.id;
			on_skyline_q      <= !tail.dominated;
			// undominated but no free slot found on the way
			window_overflow_q <= !tail.dominated && !tail.kept;
			skyline_count_q   <= COUNT_OUT_BITS'(tail.count);
			set_done_q        <= tail.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign result_id       = result_id_q;
	assign on_skyline      = on_skyline_q;
	assign window_overflow = window_overflow_q;
	assign skyline_count   = skyline_count_q;
	assign set_done        = set_done_q;

`ifndef SYNTHESIS
	a_overflow_in_sky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_overflow |-> on_skyline)
		else $error("overflow flagged on a dominated point");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && window_overflow |-> skyline_count == COUNT_OUT_BITS'(WINDOW_DEPTH))
		else $error("overflow flagged while the window had room");

	a_dominated_needs_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !on_skyline |-> skyline_count != '0)
		else $error("point dominated by an empty window");

	a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("chain moved under a stalled output");
`endif

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking testbench for skyline_window_filter_core
// drives sorted point sets, duplicates, anti-correlated fronts and unsorted noise under random
// gaps and stalls, and checks each result against a behavioral window model; needs swf_pkg
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import swf_pkg::*;

	localparam int LATENCY      = WINDOW_DEPTH + 1;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 850;

	typedef struct {
		point_t             pt;
		logic [ID_BITS-1:0] id;
		logic               last;
	} point_req_t;

	typedef struct packed {
		logic [ID_BITS-1:0]        id;
		logic                      sky;
		logic                      overflow;
		logic [COUNT_OUT_BITS-1:0] count;
		logic                      done;
	} verdict_t;

	typedef enum int {SET_NARROW, SET_WIDE, SET_FRONT, SET_COPIES, SET_NOISE} set_kind_t;

	logic                      clk        = 1'b0;
	logic                      arst_n     = 1'b0;
	logic                      cfg_valid  = 1'b0;
	logic                      cfg_ready;
	dims_t                     cfg_data   = '0;
	logic                      in_valid   = 1'b0;
	logic                      in_stall;
	logic [FIELD_BITS-1:0]     coord_a    = '0;
	logic [FIELD_BITS-1:0]     coord_b    = '0;
	logic [FIELD_BITS-1:0]     coord_c    = '0;
	logic [FIELD_BITS-1:0]     coord_d    = '0;
	logic [ID_BITS-1:0]        point_id   = '0;
	logic                      last_point = 1'b0;
	logic                      out_valid;
	logic                      out_stall  = 1'b0;
	logic [ID_BITS-1:0]        result_id;
	logic                      on_skyline;
	logic                      window_overflow;
	logic [COUNT_OUT_BITS-1:0] skyline_count;
	logic                      set_done;

	point_req_t pending_points[$];
	verdict_t   expected_verdicts[$];
	int         mismatch_count = 0;
	int         cycle_count    = 0;
	logic       in_taken       = 1'b0;
	int         in_gap         = 0;
	int         stall_left     = 0;
	bit         in_quiet       = 1'b0;
	bit         out_quiet      = 1'b0;

	// window model
	point_t kept_points [WINDOW_DEPTH];
	int     kept_total = 0;
	dims_t  dims_reg   = dims_t'(4);
	dims_t  dims_order [8] = '{3'd1, 3'd4, 3'd7, 3'd0, 3'd2, 3'd3, 3'd5, 3'd6};

	skyline_window_filter_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.coord_a         (coord_a),
		.coord_b         (coord_b),
		.coord_c         (coord_c),
		.coord_d         (coord_d),
		.point_id        (point_id),
		.last_point      (last_point),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.result_id       (result_id),
		.on_skyline      (on_skyline),
		.window_overflow (window_overflow),
		.skyline_count   (skyline_count),
		.set_done        (set_done)
	);

	always #5 clk = ~clk;

	function automatic int dims_active();
		if (dims_reg == '0) return 1;
		if (dims_reg > MAX_DIMS) return MAX_DIMS;
		return int'(dims_reg);
	endfunction

	// filter one point through the kept window, store it if it survives
	function automatic verdict_t judge_point(point_req_t r);
		verdict_t v;
		int       n;
		logic     beaten;
		logic     worse;
		logic     better;
		n      = dims_active();
		beaten = 1'b0;
		for (int s = 0; s < kept_total; s++) begin
			worse  = 1'b0;
			better = 1'b0;
			for (int k = 0; k < n; k++) begin
				if (kept_points[s][k] > r.pt[k]) worse = 1'b1;
				else if (kept_points[s][k] < r.pt[k]) better = 1'b1;
			end
			if (!worse && better) beaten = 1'b1;
		end
		v.id       = r.id;
		v.sky      = !beaten;
		v.overflow = 1'b0;
		if (!beaten) begin
			if (kept_total < WINDOW_DEPTH) begin
				kept_points[kept_total] = r.pt;
				kept_total++;
			end else begin
				v.overflow = 1'b1;
			end
		end
		v.count = COUNT_OUT_BITS'(kept_total);
		v.done  = r.last;
		if (r.last) kept_total = 0;
		return v;
	endfunction

	function automatic void check_field(string label, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0h got %0h", $time, label, want, got);
			mismatch_count++;
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [4*COORD_BITS-1:0] point_key(point_t p);
		return {p[0], p[1], p[2], p[3]};
	endfunction

	// check results, then turn each accepted request into its expected result
	always @(posedge clk) begin : monitor
		point_req_t r;
		verdict_t   want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: unexpected result, result_id %0h", $time, result_id);
					mismatch_count++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("result_id", int'(want.id), int'(result_id));
					check_field("on_skyline", int'(want.sky), int'(on_skyline));
					check_field("window_overflow", int'(want.overflow),
						int'(window_overflow));
					check_field("skyline_count", int'(want.count), int'(skyline_count));
					check_field("set_done", int'(want.done), int'(set_done));
				end
			end
			if (in_valid && !in_stall) begin
				r.pt[0] = coord_a;
				r.pt[1] = coord_b;
				r.pt[2] = coord_c;
				r.pt[3] = coord_d;
				r.id    = point_id;
				r.last  = last_point;
				expected_verdicts = {expected_verdicts, judge_point(r)};
			end
		end
		in_taken <= in_valid && !in_stall;
	end

	always @(negedge clk) begin : driver
		point_req_t r;
		if (in_valid && !in_taken) begin
			// stalled request stays on the port
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap   <= in_gap - 1;
		end else if (pending_points.size() != 0) begin
			r = pending_points.pop_front();
			coord_a    <= r.pt[0];
			coord_b    <= r.pt[1];
			coord_c    <= r.pt[2];
			coord_d    <= r.pt[3];
			point_id   <= r.id;
			last_point <= r.last;
			in_valid   <= 1'b1;
			in_gap     <= in_quiet ? 0 : idle_len();
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : receiver
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= 1'b0;
			stall_left <= out_quiet ? 0 : idle_len();
		end
	end

	task automatic add_point(coord_t a, coord_t b, coord_t c, coord_t d,
			logic [ID_BITS-1:0] id, logic last);
		point_req_t r;
		r.pt[0] = a;
		r.pt[1] = b;
		r.pt[2] = c;
		r.pt[3] = d;
		r.id    = id;
		r.last  = last;
		pending_points = {pending_points, r};
	endtask

	task automatic queue_set(set_kind_t kind, int n, bit close);
		point_req_t batch[$];
		point_req_t r;
		point_req_t t;
		int         j;
		int         span;
		span = ($urandom_range(0, 1) == 1) ? 3 : 15;
		for (int i = 0; i < n; i++) begin
			r.id   = ID_BITS'($urandom);
			r.last = 1'b0;
			case (kind)
				SET_NARROW: begin
					for (int k = 0; k < MAX_DIMS; k++) r.pt[k] = coord_t'($urandom_range(0, span));
				end
				SET_FRONT: begin
					// a rises while b falls, so nothing dominates beyond one dimension
					r.pt[0] = coord_t'($urandom);
					r.pt[1] = ~r.pt[0];
					r.pt[2] = coord_t'($urandom);
					r.pt[3] = coord_t'($urandom);
				end
				SET_COPIES: begin
					if (i == 0) begin
						for (int k = 0; k < MAX_DIMS; k++) r.pt[k] = coord_t'($urandom);
					end else begin
						r.pt = batch[0].pt;
					end
				end
				default: begin
					for (int k = 0; k < MAX_DIMS; k++) r.pt[k] = coord_t'($urandom);
				end
			endcase
			if (kind == SET_NOISE) r.last = ($urandom_range(0, 7) == 0);
			batch = {batch, r};
		end
		if (kind != SET_NOISE) begin
			for (int i = 1; i < batch.size(); i++) begin
				t = batch[i];
				j = i - 1;
				while (j >= 0 && point_key(batch[j].pt) > point_key(t.pt)) begin
					batch[j+1] = batch[j];
					j--;
				end
				batch[j+1] = t;
			end
		end
		if (close) batch[n-1].last = 1'b1;
		foreach (batch[i]) pending_points = {pending_points, batch[i]};
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_points.size() != 0 || in_valid || expected_verdicts.size() != 0);
	endtask

	task automatic write_dims(dims_t v);
		@(negedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		dims_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int        fed;
		int        phase;
		int        roll;
		int        n;
		set_kind_t kind;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset value of the dimension register, all four coordinates
		add_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
		add_point(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 1'b0);
		add_point(16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 1'b0);
		add_point(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h8000, 1'b1);
		add_point(16'h0000, 16'hffff, 16'hffff, 16'hffff, 16'h5555, 1'b0);
		add_point(16'hffff, 16'h0000, 16'hffff, 16'hffff, 16'haaaa, 1'b0);
		add_point(16'hffff, 16'hffff, 16'h0000, 16'hffff, 16'h00ff, 1'b0);
		add_point(16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'hff00, 1'b0);
		add_point(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h1234, 1'b1);
		// single-point set right after a clear
		add_point(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h7fff, 1'b1);
		// out of order: no check, both survive
		add_point(16'h0005, 16'h0005, 16'h0005, 16'h0005, 16'h0f0f, 1'b0);
		add_point(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'hf0f0, 1'b1);
		wait_drained();

		// zero dimensions behaves as one
		write_dims(dims_t'(0));
		add_point(16'h0003, 16'h0000, 16'h0000, 16'h0000, 16'h0101, 1'b0);
		add_point(16'h0003, 16'hffff, 16'hffff, 16'hffff, 16'h0202, 1'b0);
		add_point(16'h0004, 16'h0000, 16'h0000, 16'h0000, 16'h0303, 1'b1);

		fed   = 0;
		phase = 0;
		while (fed < RANDOM_ITEMS) begin
			wait_drained();
			write_dims(phase < 8 ? dims_order[phase] : dims_t'($urandom_range(0, 7)));
			in_quiet  = ($urandom_range(0, 4) == 0);
			out_quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 5)) begin
				roll = $urandom_range(0, 99);
				if (roll < 35) kind = SET_NARROW;
				else if (roll < 55) kind = SET_WIDE;
				else if (roll < 75) kind = SET_FRONT;
				else if (roll < 88) kind = SET_COPIES;
				else kind = SET_NOISE;
				// now and then a set larger than the window
				if ($urandom_range(0, 15) == 0) begin
					kind = roll[0] ? SET_FRONT : SET_COPIES;
					n    = $urandom_range(WINDOW_DEPTH + 1, WINDOW_DEPTH + 8);
				end else begin
					n = $urandom_range(1, 16);
				end
				queue_set(kind, n, $urandom_range(0, 9) != 0);
				fed += n;
			end
			phase++;
		end

		wait_drained();
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
